// File: hdl/bcrf_pkg.sv
// ----------------------------------------------------------------------------
// Bisection cubic root finder: shared package
// Types, codes and default sizes used by the root finder modules.
// ----------------------------------------------------------------------------
package bcrf_pkg;

  // Default number format: signed Q16.16.
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Field widths fixed by the result format.
  localparam int CNT_W    = 8;
  localparam int STATUS_W = 2;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 8'd32;

  // Sign of the cubic at a point.
  typedef enum logic [1:0] {
    SGN_NEG,
    SGN_ZERO,
    SGN_POS
  } sign_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_ZERO    = 2'd0,
    ST_LIMIT   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  // Result fields other than the root value.
  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] used;
  } res_info_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SIGN_A,
    S_SIGN_B,
    S_ITER,
    S_DONE
  } state_t;

endpackage

// File: hdl/bcrf_eval.sv
// ----------------------------------------------------------------------------
// Bisection cubic root finder: shared evaluation unit
// Forms the floored midpoint of two ends and the sign of the cubic at either
// the lower operand or that midpoint.
// ----------------------------------------------------------------------------
module bcrf_eval
  import bcrf_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic signed [DATA_WIDTH-1:0] lo,
  input  logic signed [DATA_WIDTH-1:0] hi,
  input  logic                         sel_mid,
  output logic signed [DATA_WIDTH-1:0] mid,
  output sign_t                        sign
);

  // The cubic factors as (x+1)((x-1)^2+1), so its sign is the sign of x+1.
  // When one unit is not representable, x+1 is positive everywhere.
  localparam bit COARSE = (FRAC_BITS > DATA_WIDTH - 1);
  localparam logic signed [DATA_WIDTH:0] NEG_ONE =
    -((DATA_WIDTH+1)'(1) << FRAC_BITS);

  logic signed [DATA_WIDTH:0] sum;
  logic signed [DATA_WIDTH-1:0] x;
  logic signed [DATA_WIDTH:0] x_ext;

  assign sum   = {lo[DATA_WIDTH-1], lo} + {hi[DATA_WIDTH-1], hi};
  assign mid   = sum[DATA_WIDTH:1];
  assign x     = sel_mid ? mid : lo;
  assign x_ext = {x[DATA_WIDTH-1], x};

  always_comb begin
    if (COARSE) begin
      sign = SGN_POS;
    end else if (x_ext > NEG_ONE) begin
      sign = SGN_POS;
    end else if (x_ext == NEG_ONE) begin
      sign = SGN_ZERO;
    end else begin
      sign = SGN_NEG;
    end
  end

endmodule

// File: hdl/bcrf_ctrl.sv
// ----------------------------------------------------------------------------
// Bisection cubic root finder: sequencer
// Checks the interval ends and then runs one bisection step per cycle on the
// shared evaluation unit until an exact zero or the iteration limit.
// ----------------------------------------------------------------------------
module bcrf_ctrl
  import bcrf_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic signed [DATA_WIDTH-1:0] req_left,
  input  logic signed [DATA_WIDTH-1:0] req_right,
  input  logic [CNT_W-1:0]             limit,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic signed [DATA_WIDTH-1:0] res_root,
  output res_info_t                    res_info
);

  state_t state, state_next;

  logic signed [DATA_WIDTH-1:0] a, a_next;
  logic signed [DATA_WIDTH-1:0] b, b_next;
  logic signed [DATA_WIDTH-1:0] c, c_next;
  sign_t                        sa, sa_next;
  logic [CNT_W-1:0]             cnt, cnt_next;
  res_info_t                    info, info_next;

  logic signed [DATA_WIDTH-1:0] eval_lo;
  logic                         eval_sel_mid;
  logic signed [DATA_WIDTH-1:0] eval_mid;
  sign_t                        eval_sign;
  logic [CNT_W-1:0]             cnt_inc;

  bcrf_eval #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_eval (
    .lo      (eval_lo),
    .hi      (b),
    .sel_mid (eval_sel_mid),
    .mid     (eval_mid),
    .sign    (eval_sign)
  );

  assign cnt_inc = cnt + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    a    <= a_next;
    b    <= b_next;
    c    <= c_next;
    sa   <= sa_next;
    cnt  <= cnt_next;
    info <= info_next;
  end

  always_comb begin
    state_next   = state;
    a_next       = a;
    b_next       = b;
    c_next       = c;
    sa_next      = sa;
    cnt_next     = cnt;
    info_next    = info;
    req_ready    = 1'b0;
    res_valid    = 1'b0;
    eval_lo      = a;
    eval_sel_mid = 1'b0;

    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          a_next     = req_left;
          b_next     = req_right;
          c_next     = '0;
          cnt_next   = '0;
          state_next = S_SIGN_A;
        end
      end
      S_SIGN_A: begin
        eval_lo    = a;
        sa_next    = eval_sign;
        state_next = S_SIGN_B;
      end
      S_SIGN_B: begin
        eval_lo = b;
        if (sa == SGN_ZERO || eval_sign == SGN_ZERO || sa == eval_sign) begin
          info_next.status = ST_INVALID;
          info_next.used   = '0;
          state_next       = S_DONE;
        end else if (limit == '0) begin
          info_next.status = ST_LIMIT;
          info_next.used   = '0;
          state_next       = S_DONE;
        end else begin
          state_next = S_ITER;
        end
      end
      S_ITER: begin
        eval_lo      = a;
        eval_sel_mid = 1'b1;
        c_next       = eval_mid;
        cnt_next     = cnt_inc;
        if (eval_sign == SGN_ZERO) begin
          info_next.status = ST_ZERO;
          info_next.used   = cnt_inc;
          state_next       = S_DONE;
        end else begin
          if (sa != eval_sign) begin
            b_next = eval_mid;
          end else begin
            a_next = eval_mid;
          end
          if (cnt_inc == limit) begin
            info_next.status = ST_LIMIT;
            info_next.used   = limit;
            state_next       = S_DONE;
          end
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res_root = c;
  assign res_info = info;

  // An invalid interval never computes a midpoint.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_info.status == ST_INVALID) |-> (res_info.used == '0 && res_root == '0))
    else $error("invalid interval result carries a midpoint or a count");

  // The step counter stays below the limit while bisecting.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ITER) |-> (cnt < limit))
    else $error("bisection step counter reached the limit");

  // A request is taken only when no result is pending.
  assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !res_valid)
    else $error("request accepted while a result is pending");

endmodule

// File: hdl/bisection_cubic_root_finder.sv
// ----------------------------------------------------------------------------
// Bisection cubic root finder: top level
// Finds a root of x^3 - x^2 + 2 inside a signed fixed-point interval.
// ----------------------------------------------------------------------------
// The slave stream takes one request per interval: tdata holds left_end in
// the low DATA_WIDTH bits and right_end above it. The master stream returns
// one result per request: root, status and iterations_used, packed from the
// low bit up. Status 0 means an exact zero was hit, 1 means the iteration
// limit ran out and 2 means f does not change sign strictly over the interval.
// The iteration limit is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while the block is idle, as the block does not enforce
// this. It resets to 32. A request passes through the two end-point sign
// tests and then runs one bisection step per cycle on the shared midpoint and
// sign unit; the sequencer holds the result in its done state, and the output
// register then shows it on the master stream. An invalid interval goes from
// the sign tests straight to the done state.
// Only one request is in work at a time; s_axis_tready is high while the
// sequencer is idle. A finished result waits in the output register while the
// receiver stalls, and the sequencer may already take the next request; a
// second result then waits in the sequencer until the register frees up.
// Synchronous reset returns to idle, drops m_axis_tvalid and restores the
// iteration limit.
// ----------------------------------------------------------------------------
module bisection_cubic_root_finder
  import bcrf_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int IN_W      = ((2 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_W     = ((DATA_WIDTH + STATUS_W + CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // Configuration: iteration_limit.
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  // Request stream.
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // left_end, right_end, zero fill
  // Result stream.
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata    // root, status, iterations_used, zero fill
);

  localparam int USED_W = DATA_WIDTH + STATUS_W + CNT_W;

  logic [CNT_W-1:0]             iteration_limit;
  logic                         res_valid;
  logic                         res_ready;
  logic signed [DATA_WIDTH-1:0] res_root;
  res_info_t                    res_info;
  logic                         out_valid;
  logic [USED_W-1:0]            out_data;

  // The iteration limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      iteration_limit <= cfg_wr_data;
    end
  end

  bcrf_ctrl #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .req_left  (s_axis_tdata[DATA_WIDTH-1:0]),
    .req_right (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .limit     (iteration_limit),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_root  (res_root),
    .res_info  (res_info)
  );

  // Output register: it takes a result whenever it is empty or being drained.
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= {res_info.used, res_info.status, res_root};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'(out_data);

endmodule
